// ----- rtl/srct_pkg.sv -----
// ============================================================================
// srct_pkg: shared definitions for the sync root counter timer
// Command codes, the mode register layout and the packing of the stream words.
// ============================================================================
`default_nettype none

package srct_pkg;

  // Command carried in the input tuser.
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Blank synchronization modes.
  typedef enum logic [1:0] {
    SYNC_PAUSE  = 2'd0,
    SYNC_RESET  = 2'd1,
    SYNC_WINDOW = 2'd2,
    SYNC_FREE   = 2'd3
  } sync_mode_t;

  // Mode register, most significant field first (bit 0 is sync_enable).
  typedef struct packed {
    logic [1:0] clock_select;
    logic       pulse_flag;
    logic       repeat_flag;
    logic       max_irq_enable;
    logic       target_irq_enable;
    logic       wrap_at_target;
    sync_mode_t sync_mode;
    logic       sync_enable;
  } mode_t;

  localparam int unsigned TIMER_ID_DEFAULT = 0;
  localparam int unsigned TIMER_SYSCLK     = 2;

  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned MODE_W      = 10;
  localparam int unsigned READ_W      = 13;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  // Input word: blank at bit 0, mode_data above it, padded to two bytes.
  localparam int unsigned S_DATA_W = 16;
  localparam int unsigned S_USER_W = 2;

  // Output word: read_data, count, irq_request, irq_bit, padded to four bytes.
  localparam int unsigned M_DATA_W     = 32;
  localparam int unsigned OUT_COUNT_LO = READ_W;
  localparam int unsigned OUT_REQ_BIT  = READ_W + COUNT_W;
  localparam int unsigned OUT_IRQ_BIT  = OUT_REQ_BIT + 1;

endpackage

`default_nettype wire

// ----- rtl/sync_root_counter_timer_top.sv -----
// ============================================================================
// sync_root_counter_timer_top: 16-bit root counter with mode and target
// A counter that ticks, wraps at its target or at its maximum, follows blank
// sync rules and reports mode and status on a read.
// ============================================================================
//
// Channel   Direction  Signals                           Contents
// --------  ---------  --------------------------------  ----------------------------
// s_*       in         s_tvalid s_tready s_tdata s_tuser  one tick, mode write or read
// m_*       out        m_tvalid m_tready m_tdata          one result per input word
// cfg_*     in         cfg_valid cfg_ready cfg_data       counter target value
//
// Each word passes from the input register into the output register, so a word
// can be accepted every cycle while the output is not stalled. The rate is set by
// the single counter update path (16-bit compares and increment) between the input
// register and the state registers. A result that is not taken holds the output
// register; the input register then keeps its word and s_tready drops until the
// result leaves. Synchronous reset loads the documented state values and empties
// both stages. The target register is always ready; the user must write it only
// while the block is idle. The block itself does not enforce this.
`default_nettype none

module sync_root_counter_timer_top #(
  parameter int unsigned TIMER_ID = srct_pkg::TIMER_ID_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Input stream.
  input  wire logic                          s_tvalid,
  output      logic                          s_tready,
  // s_tdata: [0] blank, [10:1] mode_data, [15:11] zero
  input  wire logic [srct_pkg::S_DATA_W-1:0] s_tdata,
  // s_tuser: [1:0] cmd
  input  wire logic [srct_pkg::S_USER_W-1:0] s_tuser,
  // Output stream.
  output      logic                          m_tvalid,
  input  wire logic                          m_tready,
  // m_tdata: [12:0] read_data, [28:13] count, [29] irq_request, [30] irq_bit,
  //          [31] zero
  output      logic [srct_pkg::M_DATA_W-1:0] m_tdata,
  // Target register write.
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [srct_pkg::COUNT_W-1:0]  cfg_data
);

  // Input register.
  logic                            in_valid;
  srct_pkg::cmd_t                  in_cmd;
  logic                            in_blank;
  logic [srct_pkg::MODE_W-1:0]     in_mode_data;

  // Output register.
  logic                            out_valid;
  logic [srct_pkg::READ_W-1:0]     out_read_data;
  logic [srct_pkg::COUNT_W-1:0]    out_count;
  logic                            out_irq_request;
  logic                            out_irq_bit;

  // Timer state.
  logic [srct_pkg::COUNT_W-1:0]    target;
  logic [srct_pkg::COUNT_W-1:0]    counter;
  srct_pkg::mode_t                 mode;
  logic                            irq_status;
  logic                            hit_target;
  logic                            hit_max;
  logic                            inside_blank;

  // Next values.
  logic [srct_pkg::COUNT_W-1:0]    counter_next;
  srct_pkg::mode_t                 mode_next;
  logic                            irq_status_next;
  logic                            hit_target_next;
  logic                            hit_max_next;
  logic                            inside_blank_next;
  logic [srct_pkg::READ_W-1:0]     read_data_next;
  logic                            irq_request_next;

  logic                            step;
  logic                            advance;

  // The input word moves on whenever the output register is free or emptying.
  assign step      = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || step;
  assign cfg_ready = 1'b1;

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_irq_bit, out_irq_request, out_count, out_read_data};

  // Per command: for a tick, sync rules decide whether it counts, then the wrap logic runs.
  always_comb begin
    counter_next      = counter;
    mode_next         = mode;
    irq_status_next   = irq_status;
    hit_target_next   = hit_target;
    hit_max_next      = hit_max;
    inside_blank_next = inside_blank;
    read_data_next    = '0;
    irq_request_next  = 1'b0;
    advance           = 1'b0;

    case (in_cmd)
      srct_pkg::CMD_TICK: begin
        if (!mode.sync_enable) begin
          advance = 1'b1;
        end else if (TIMER_ID == srct_pkg::TIMER_SYSCLK) begin
          // The third timer only counts in the two blank-reset modes.
          advance = (mode.sync_mode == srct_pkg::SYNC_RESET) ||
                    (mode.sync_mode == srct_pkg::SYNC_WINDOW);
        end else begin
          case (mode.sync_mode)
            srct_pkg::SYNC_PAUSE: begin
              advance = !in_blank;
            end
            srct_pkg::SYNC_RESET, srct_pkg::SYNC_WINDOW: begin
              if (in_blank && !inside_blank) begin
                // Entering blank clears the count and takes no step.
                inside_blank_next = 1'b1;
                counter_next      = '0;
              end else if (in_blank) begin
                advance = 1'b1;
              end else begin
                inside_blank_next = 1'b0;
                advance           = (mode.sync_mode == srct_pkg::SYNC_RESET);
              end
            end
            srct_pkg::SYNC_FREE: begin
              // Wait for blank, then drop to free run without counting.
              if (in_blank) begin
                mode_next.sync_enable = 1'b0;
              end
            end
            default: begin
              advance = 1'b0;
            end
          endcase
        end

        if (advance) begin
          if (mode.wrap_at_target) begin
            if (counter == target) begin
              counter_next    = '0;
              hit_target_next = 1'b1;
              if (mode.target_irq_enable) begin
                irq_status_next  = 1'b0;
                irq_request_next = 1'b1;
              end
            end else begin
              counter_next = counter + 1'b1;
            end
          end else begin
            if (counter == srct_pkg::COUNT_MAX) begin
              counter_next = '0;
              hit_max_next = 1'b1;
              if (mode.max_irq_enable) begin
                irq_status_next  = 1'b0;
                irq_request_next = 1'b1;
              end
            end else begin
              counter_next = counter + 1'b1;
            end
          end
        end
      end
      srct_pkg::CMD_WRITE: begin
        mode_next       = srct_pkg::mode_t'(in_mode_data);
        counter_next    = '0;
        irq_status_next = 1'b1;
      end
      srct_pkg::CMD_READ: begin
        // Status is reported before the read clears the wrap flags.
        read_data_next  = {hit_max, hit_target, irq_status, mode};
        hit_target_next = 1'b0;
        hit_max_next    = 1'b0;
      end
      default: begin
        read_data_next = '0;
      end
    endcase
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      out_valid    <= 1'b0;
      target       <= '0;
      counter      <= '0;
      mode         <= '0;
      irq_status   <= 1'b1;
      hit_target   <= 1'b0;
      hit_max      <= 1'b0;
      inside_blank <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        target <= cfg_data;
      end
      if (step) begin
        counter      <= counter_next;
        mode         <= mode_next;
        irq_status   <= irq_status_next;
        hit_target   <= hit_target_next;
        hit_max      <= hit_max_next;
        inside_blank <= inside_blank_next;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_cmd       <= srct_pkg::cmd_t'(s_tuser);
      in_blank     <= s_tdata[0];
      in_mode_data <= s_tdata[srct_pkg::MODE_W:1];
    end
    if (step) begin
      out_read_data   <= read_data_next;
      out_count       <= counter_next;
      out_irq_request <= irq_request_next;
      out_irq_bit     <= irq_status_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/srct_checker.sv -----
// ============================================================================
// srct_checker: port-level checks for the sync root counter timer
// Watches the output stream for reset behavior, stall holding and interrupt consistency.
// ============================================================================
`default_nettype none

module srct_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [srct_pkg::M_DATA_W-1:0] m_tdata
);

  // No result survives a reset.
  a_reset_empty : assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // A waiting result stays put.
  a_stall_hold : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  // An interrupt request always pulls the status bit low.
  a_req_bit : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[srct_pkg::OUT_REQ_BIT] |-> !m_tdata[srct_pkg::OUT_IRQ_BIT])
    else $error("irq_request without irq_bit low");

  // An interrupt only comes from a wrap, which leaves the counter at zero.
  a_req_wrap : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[srct_pkg::OUT_REQ_BIT] |->
      m_tdata[srct_pkg::OUT_REQ_BIT-1:srct_pkg::OUT_COUNT_LO] == '0)
    else $error("irq_request with nonzero count");

endmodule

bind sync_root_counter_timer_top srct_checker u_srct_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- tb/srct_checker.sv -----
// ============================================================================
// srct_scoreboard: result predictor and scoreboard for the root counter timer
// Watches the input, target and result channels, predicts one result word
// for every accepted input word and compares the results in order.
// ============================================================================
module srct_scoreboard #(
  parameter int unsigned TIMER_ID = srct_pkg::TIMER_ID_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  // Same bit order as m_tdata[30:0].
  typedef struct packed {
    logic        irq_bit;
    logic        irq_request;
    logic [15:0] count;
    logic [12:0] read_data;
  } timer_result_t;

  logic [15:0]     target_q;
  logic [15:0]     counter_q;
  srct_pkg::mode_t mode_q;
  logic            irq_status_q;
  logic            hit_target_q;
  logic            hit_max_q;
  logic            inside_blank_q;
  timer_result_t   expected_words[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // One counting step; returns 1 when an enabled interrupt fires.
  function automatic logic advance_counter();
    logic fired;
    fired = 1'b0;
    if (mode_q.wrap_at_target) begin
      if (counter_q == target_q) begin
        if (mode_q.target_irq_enable) begin
          irq_status_q = 1'b0;
          fired        = 1'b1;
        end
        hit_target_q = 1'b1;
        counter_q    = '0;
      end else begin
        counter_q = counter_q + 16'd1;
      end
    end else begin
      if (counter_q == srct_pkg::COUNT_MAX) begin
        if (mode_q.max_irq_enable) begin
          irq_status_q = 1'b0;
          fired        = 1'b1;
        end
        hit_max_q = 1'b1;
        counter_q = '0;
      end else begin
        counter_q = counter_q + 16'd1;
      end
    end
    return fired;
  endfunction

  function automatic logic apply_tick(input logic blank);
    if (!mode_q.sync_enable)
      return advance_counter();
    if (TIMER_ID == srct_pkg::TIMER_SYSCLK) begin
      if (mode_q.sync_mode == srct_pkg::SYNC_RESET ||
          mode_q.sync_mode == srct_pkg::SYNC_WINDOW)
        return advance_counter();
      return 1'b0;
    end
    case (mode_q.sync_mode)
      srct_pkg::SYNC_PAUSE: begin
        if (blank)
          return 1'b0;
        return advance_counter();
      end
      srct_pkg::SYNC_RESET, srct_pkg::SYNC_WINDOW: begin
        if (blank && !inside_blank_q) begin
          inside_blank_q = 1'b1;
          counter_q      = '0;
          return 1'b0;
        end
        if (blank)
          return advance_counter();
        inside_blank_q = 1'b0;
        if (mode_q.sync_mode == srct_pkg::SYNC_RESET)
          return advance_counter();
        return 1'b0;
      end
      default: begin
        // Blank releases the counter into free run.
        if (blank)
          mode_q.sync_enable = 1'b0;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic timer_result_t step_timer(input srct_pkg::cmd_t cmd,
                                               input logic blank,
                                               input logic [9:0] mode_bits);
    timer_result_t r;
    r = '0;
    case (cmd)
      srct_pkg::CMD_TICK: r.irq_request = apply_tick(blank);
      srct_pkg::CMD_WRITE: begin
        mode_q       = srct_pkg::mode_t'(mode_bits);
        irq_status_q = 1'b1;
        counter_q    = '0;
      end
      srct_pkg::CMD_READ: begin
        r.read_data  = {hit_max_q, hit_target_q, irq_status_q, mode_q};
        hit_target_q = 1'b0;
        hit_max_q    = 1'b0;
      end
      default: ;
    endcase
    r.count   = counter_q;
    r.irq_bit = irq_status_q;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    timer_result_t want;
    timer_result_t got;
    if (rst) begin
      target_q       = '0;
      counter_q      = '0;
      mode_q         = '0;
      irq_status_q   = 1'b1;
      hit_target_q   = 1'b0;
      hit_max_q      = 1'b0;
      inside_blank_q = 1'b0;
      expected_words.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        target_q = cfg_data;
      if (s_tvalid && s_tready)
        expected_words.push_back(step_timer(srct_pkg::cmd_t'(s_tuser), s_tdata[0],
                                            s_tdata[10:1]));
      if (m_tvalid && m_tready) begin
        got = m_tdata[30:0];
        if (expected_words.size() == 0) begin
          $error("result word %h arrived with nothing expected", m_tdata);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (got.read_data !== want.read_data) begin
            $error("read_data: expected %h, actual %h", want.read_data, got.read_data);
            fail_count++;
          end
          if (got.count !== want.count) begin
            $error("count: expected %h, actual %h", want.count, got.count);
            fail_count++;
          end
          if (got.irq_request !== want.irq_request) begin
            $error("irq_request: expected %b, actual %b", want.irq_request, got.irq_request);
            fail_count++;
          end
          if (got.irq_bit !== want.irq_bit) begin
            $error("irq_bit: expected %b, actual %b", want.irq_bit, got.irq_bit);
            fail_count++;
          end
        end
      end
    end
    pending <= expected_words.size();
  end

endmodule

// ----- tb/testbench.sv -----
// ============================================================================
// testbench: stimulus and verdict for the sync root counter timer
// Drives directed and random command words (ticks, mode writes, mode reads)
// through the input stream with random gaps and result stalls, changes the
// target between phases, and lets the checker compare every result word.
// ============================================================================
module testbench;

  localparam int unsigned TIMER_ID       = srct_pkg::TIMER_ID_DEFAULT;
  // Longest correct quiet stretch is the longest random gap plus the longest stall plus
  // two pipeline stages; the limit is many times that.
  localparam int          WATCHDOG_LIMIT = 500;
  localparam int          DRAIN_CYCLES   = 8;
  localparam int          PHASES         = 8;
  localparam int          PHASE_WORDS    = 250;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata   = '0;
  logic [1:0]  s_tuser   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [31:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data  = '0;

  int fail_count;
  int pending;
  int idle_cycles = 0;

  // When set, neither the sender nor the receiver inserts any idle cycles.
  logic steady = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sync_root_counter_timer_top #(.TIMER_ID(TIMER_ID)) uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // [0] blank, [10:1] mode_data, [15:11] zero
    .s_tuser   (s_tuser),   // [1:0] cmd
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // [12:0] read_data, [28:13] count, [29] irq_request,
                            // [30] irq_bit, [31] zero
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  srct_scoreboard #(.TIMER_ID(TIMER_ID)) checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // The watchdog restarts on any word moving on any channel. A hang anywhere
  // in the block shows up as a long run of cycles where nothing moves.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result receiver: before every result word it stalls a random number of
  // cycles, then holds tready high until a word is taken. tready is touched
  // at most once per edge, so a zero stall keeps it high without a glitch.
  initial begin : result_sink
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // Sends one command word after a random gap and returns at the edge where
  // it is taken. tvalid stays high into the next word when the gap is zero.
  task automatic issue_word(input srct_pkg::cmd_t cmd, input logic blank,
                            input logic [9:0] mode_bits);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {5'b0, mode_bits, blank};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stops sending and waits until every outstanding result word is back.
  // Every command word gives exactly one result, so the block is idle then.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // The target may only change while the block is idle.
  task automatic load_target(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int             sent;
    int             run;
    logic [9:0]     mode_bits;
    logic           blank_level;
    srct_pkg::cmd_t noise_cmd;
    logic [15:0]    new_target;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. A small target makes the target wrap quick to reach.
    load_target(16'd2);
    issue_word(srct_pkg::CMD_READ, 1'b0, 10'h000);   // status right after reset
    issue_word(srct_pkg::CMD_TICK, 1'b0, 10'h000);
    issue_word(srct_pkg::CMD_TICK, 1'b1, 10'h000);   // sync off, blank is ignored
    issue_word(srct_pkg::CMD_NONE, 1'b1, 10'h3FF);   // unused command changes nothing
    // Wrap at target with its interrupt enabled: 1, 2, then wrap and fire.
    issue_word(srct_pkg::CMD_WRITE, 1'b0, 10'h018);
    repeat (3) issue_word(srct_pkg::CMD_TICK, 1'b0, 10'h000);
    issue_word(srct_pkg::CMD_READ, 1'b0, 10'h000);   // shows the target flag and IRQ low
    issue_word(srct_pkg::CMD_READ, 1'b0, 10'h000);   // flags cleared by the first read
    // Every mode bit set: sync mode 3 holds until blank, then runs free.
    issue_word(srct_pkg::CMD_WRITE, 1'b1, 10'h3FF);
    issue_word(srct_pkg::CMD_TICK, 1'b0, 10'h000);
    issue_word(srct_pkg::CMD_TICK, 1'b1, 10'h000);
    issue_word(srct_pkg::CMD_TICK, 1'b0, 10'h000);
    issue_word(srct_pkg::CMD_READ, 1'b1, 10'h000);
    // Sync mode 0: pause while blank is high.
    issue_word(srct_pkg::CMD_WRITE, 1'b0, 10'h001);
    issue_word(srct_pkg::CMD_TICK, 1'b1, 10'h000);
    issue_word(srct_pkg::CMD_TICK, 1'b0, 10'h000);
    // Sync mode 1: clear on blank entry, count everywhere else.
    issue_word(srct_pkg::CMD_WRITE, 1'b0, 10'h003);
    issue_word(srct_pkg::CMD_TICK, 1'b0, 10'h000);
    issue_word(srct_pkg::CMD_TICK, 1'b1, 10'h000);
    issue_word(srct_pkg::CMD_TICK, 1'b1, 10'h000);
    issue_word(srct_pkg::CMD_TICK, 1'b0, 10'h000);
    // Sync mode 2: clear on blank entry, count only inside blank.
    issue_word(srct_pkg::CMD_WRITE, 1'b0, 10'h005);
    issue_word(srct_pkg::CMD_TICK, 1'b0, 10'h000);
    issue_word(srct_pkg::CMD_TICK, 1'b1, 10'h000);
    issue_word(srct_pkg::CMD_TICK, 1'b1, 10'h000);
    issue_word(srct_pkg::CMD_TICK, 1'b0, 10'h000);

    // Random phases. Each one starts from an idle block with a new target,
    // the two extremes first and then mostly small values so that target
    // wraps happen often. Most traffic is a mode write followed by a run of
    // ticks with slowly changing blank and the odd read; the rest is noise.
    blank_level = 1'b0;
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      if (phase == 0)
        new_target = 16'h0000;
      else if (phase == 1)
        new_target = 16'hFFFF;
      else if ($urandom_range(0, 3) == 0)
        new_target = 16'($urandom_range(0, 65535));
      else
        new_target = 16'($urandom_range(0, 24));
      load_target(new_target);
      steady = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < PHASE_WORDS) begin
        if ($urandom_range(0, 9) == 0) begin
          noise_cmd = srct_pkg::cmd_t'(2'($urandom_range(0, 3)));
          issue_word(noise_cmd, 1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)));
          if (noise_cmd != srct_pkg::CMD_NONE)
            sent++;
        end else begin
          mode_bits = 10'($urandom_range(0, 1023));
          if ($urandom_range(0, 3) != 0)
            mode_bits[3] = 1'b1;
          issue_word(srct_pkg::CMD_WRITE, 1'($urandom_range(0, 1)), mode_bits);
          sent++;
          run = $urandom_range(1, 40);
          repeat (run) begin
            if ($urandom_range(0, 4) == 0)
              blank_level = ~blank_level;
            if ($urandom_range(0, 7) == 0)
              issue_word(srct_pkg::CMD_READ, 1'($urandom_range(0, 1)),
                         10'($urandom_range(0, 1023)));
            else
              issue_word(srct_pkg::CMD_TICK, blank_level, 10'($urandom_range(0, 1023)));
            sent++;
          end
        end
      end
    end

    // Let the last results come back, then give a stray word time to show up.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/srct_pkg.sv
rtl/sync_root_counter_timer_top.sv
rtl/srct_checker.sv
tb/srct_checker.sv
tb/testbench.sv
